/* src/adsr_pkg.sv */
// ----------------------------------------------------------------------------
// adsr_pkg
// shared types and codes for the one-voice envelope generator
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned STAGE_W  = 3;
    localparam int unsigned ACTION_W = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

    // requested operation for one transaction
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK     = 2'd0,
        ACT_NOTE_ON  = 2'd1,
        ACT_NOTE_OFF = 2'd2
    } t_action;

    // internal envelope phase
    typedef enum logic [1:0] {
        PH_NONE    = 2'd0,
        PH_SUSTAIN = 2'd1,
        PH_DECAY   = 2'd2,
        PH_ATTACK  = 2'd3
    } t_phase;

    // reported stage codes
    localparam logic [STAGE_W-1:0] STAGE_IDLE    = 3'd0;
    localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_DECAY   = 3'd2;
    localparam logic [STAGE_W-1:0] STAGE_SUSTAIN = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_RELEASE = 3'd4;
    localparam logic [STAGE_W-1:0] STAGE_ECHO    = 3'd5;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LEVEL_W-1:0]  attack_step;
        logic [LEVEL_W-1:0]  decay_factor;
        logic [LEVEL_W-1:0]  sustain_level;
        logic [LEVEL_W-1:0]  release_factor;
        logic [LEVEL_W-1:0]  echo_level;
    } t_in_item;

    typedef struct packed {
        logic                active;
        logic [LEVEL_W-1:0]  envelope_level;
        logic [STAGE_W-1:0]  stage;
    } t_out_item;

endpackage

/* src/adsr_echo_envelope.sv */
// ----------------------------------------------------------------------------
// adsr_echo_envelope
// one-voice envelope generator: attack, decay, sustain, release, echo tail
// ----------------------------------------------------------------------------
// usage
//   input channel : i_valid / o_stall / i_data. each transaction is a frame
//                   tick, a note on (with its five envelope parameters) or a
//                   note off. a transaction is taken when i_valid is high and
//                   o_stall is low
//   output channel: o_valid / i_stall / o_data. exactly one result per input
//                   transaction, in order: active flag, level and stage
//   result        : computed from the updated state and registered in the
//                   output register when the input transaction is taken
//   throughput    : one transaction per cycle while o_stall is low; the state
//                   update is a single 8x8 multiply plus an add/compare, done
//                   in the cycle the transaction is taken
//   stall         : when the output register holds an untaken result and
//                   i_stall is high, o_stall goes high; while the result is
//                   being taken a new input transaction is accepted in the
//                   same cycle
//   reset         : synchronous, active low; voice idle, level and all
//                   latched parameters zero, output register empty
// ----------------------------------------------------------------------------
module adsr_echo_envelope (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  adsr_pkg::t_in_item  i_data,
    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output adsr_pkg::t_out_item o_data
);

    localparam int unsigned LW = adsr_pkg::LEVEL_W;

    // voice state
    adsr_pkg::t_phase r_phase, n_phase;
    logic             r_start, n_start;      // note on not yet taken by a tick
    logic             r_stop, n_stop;        // note off seen
    logic             r_echo, n_echo;        // in echo tail
    logic [LW-1:0]    r_level, n_level;
    logic [LW-1:0]    r_echo_cnt, n_echo_cnt;
    logic [LW-1:0]    r_attack, n_attack;
    logic [LW-1:0]    r_decay, n_decay;
    logic [LW-1:0]    r_sustain, n_sustain;
    logic [LW-1:0]    r_release, n_release;

    // output register
    logic                r_out_valid;
    adsr_pkg::t_out_item r_out;
    adsr_pkg::t_out_item n_out;

    logic             in_take;
    logic             voice_on;
    logic             n_voice_on;
    logic [LW-1:0]    factor;
    logic [2*LW-1:0]  product;
    logic [LW-1:0]    scaled;
    logic [LW:0]      attack_sum;

    // output register can be refilled when empty or being drained
    assign o_stall = r_out_valid & i_stall;
    assign in_take = i_valid & ~o_stall;

    assign voice_on = r_start | r_stop | r_echo | (r_phase != adsr_pkg::PH_NONE);

    // one shared multiplier: release once note off is seen, decay otherwise
    assign factor     = r_stop ? r_release : r_decay;
    assign product    = r_level * factor;
    assign scaled     = product[2*LW-1:LW];
    assign attack_sum = {1'b0, r_level} + {1'b0, r_attack};

    // next voice state for the incoming transaction
    always_comb begin
        n_phase    = r_phase;
        n_start    = r_start;
        n_stop     = r_stop;
        n_echo     = r_echo;
        n_level    = r_level;
        n_echo_cnt = r_echo_cnt;
        n_attack   = r_attack;
        n_decay    = r_decay;
        n_sustain  = r_sustain;
        n_release  = r_release;

        unique case (adsr_pkg::t_action'(i_data.action))
            adsr_pkg::ACT_TICK: begin
                if (voice_on) begin
                    if (r_start) begin
                        if (r_stop) begin
                            // start and stop both pending: cancel the voice
                            n_phase = adsr_pkg::PH_NONE;
                            n_start = 1'b0;
                            n_stop  = 1'b0;
                            n_echo  = 1'b0;
                        end else begin
                            // restart from zero, first attack frame cannot overflow
                            n_start = 1'b0;
                            n_phase = adsr_pkg::PH_ATTACK;
                            n_level = r_attack;
                        end
                    end else if (r_echo) begin
                        n_echo_cnt = r_echo_cnt - 1'b1;
                        if (n_echo_cnt == '0) begin
                            n_phase = adsr_pkg::PH_NONE;
                            n_stop  = 1'b0;
                            n_echo  = 1'b0;
                        end
                    end else if (r_stop) begin
                        n_level = scaled;
                        if (scaled <= r_echo_cnt) begin
                            if (r_echo_cnt == '0) begin
                                n_phase = adsr_pkg::PH_NONE;
                                n_stop  = 1'b0;
                            end else begin
                                n_echo = 1'b1;
                            end
                        end
                    end else if (r_phase == adsr_pkg::PH_ATTACK) begin
                        // leave attack only when the sum overflows
                        if (attack_sum[LW]) begin
                            n_level = adsr_pkg::LEVEL_MAX;
                            n_phase = adsr_pkg::PH_DECAY;
                        end else begin
                            n_level = attack_sum[LW-1:0];
                        end
                    end else if (r_phase == adsr_pkg::PH_DECAY) begin
                        n_level = scaled;
                        if (scaled <= r_sustain) begin
                            if (r_sustain == '0) begin
                                // zero sustain goes straight to the echo tail, or ends on an empty tail
                                if (r_echo_cnt == '0) begin
                                    n_phase = adsr_pkg::PH_NONE;
                                end else begin
                                    n_echo = 1'b1;
                                end
                            end else begin
                                n_level = r_sustain;
                                n_phase = adsr_pkg::PH_SUSTAIN;
                            end
                        end
                    end
                end
            end
            adsr_pkg::ACT_NOTE_ON: begin
                n_attack   = i_data.attack_step;
                n_decay    = i_data.decay_factor;
                n_sustain  = i_data.sustain_level;
                n_release  = i_data.release_factor;
                n_echo_cnt = i_data.echo_level;
                n_phase    = adsr_pkg::PH_NONE;
                n_stop     = 1'b0;
                n_echo     = 1'b0;
                n_start    = 1'b1;
            end
            adsr_pkg::ACT_NOTE_OFF: begin
                // ignored while idle
                if (voice_on) begin
                    n_stop = 1'b1;
                end
            end
            default: begin
                // unused action only reports the current state
            end
        endcase
    end

    // result from the updated state
    assign n_voice_on = n_start | n_stop | n_echo | (n_phase != adsr_pkg::PH_NONE);

    always_comb begin
        n_out.active         = n_voice_on;
        n_out.envelope_level = n_level;
        if (!n_voice_on) begin
            n_out.stage = adsr_pkg::STAGE_IDLE;
        end else if (n_echo) begin
            n_out.stage = adsr_pkg::STAGE_ECHO;
        end else if (n_stop) begin
            n_out.stage = adsr_pkg::STAGE_RELEASE;
        end else if (n_start) begin
            n_out.stage = adsr_pkg::STAGE_ATTACK;
        end else begin
            unique case (n_phase)
                adsr_pkg::PH_ATTACK:  n_out.stage = adsr_pkg::STAGE_ATTACK;
                adsr_pkg::PH_DECAY:   n_out.stage = adsr_pkg::STAGE_DECAY;
                adsr_pkg::PH_SUSTAIN: n_out.stage = adsr_pkg::STAGE_SUSTAIN;
                default:              n_out.stage = adsr_pkg::STAGE_RELEASE;
            endcase
        end
    end

    // voice state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= adsr_pkg::PH_NONE;
            r_start    <= 1'b0;
            r_stop     <= 1'b0;
            r_echo     <= 1'b0;
            r_level    <= '0;
            r_echo_cnt <= '0;
            r_attack   <= '0;
            r_decay    <= '0;
            r_sustain  <= '0;
            r_release  <= '0;
        end else if (in_take) begin
            r_phase    <= n_phase;
            r_start    <= n_start;
            r_stop     <= n_stop;
            r_echo     <= n_echo;
            r_level    <= n_level;
            r_echo_cnt <= n_echo_cnt;
            r_attack   <= n_attack;
            r_decay    <= n_decay;
            r_sustain  <= n_sustain;
            r_release  <= n_release;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the one-voice envelope generator: a transaction-level
// predictor tracks the voice state and checks every result in order, under
// random idling on both channels, a long output hold-off and a full drain
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // the action field is two bits wide, the top code has no meaning
    localparam logic [adsr_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT   = 300_000;
    localparam int unsigned ITEMS_PER_RUN = 130;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned TAIL_CYCLES   = 10;

    // ------------------------------------------------------------------------
    // envelope predictor and result store
    // ------------------------------------------------------------------------
    class envelope_scoreboard;
        adsr_pkg::t_phase             phase;
        bit                           start_pending;
        bit                           stop_flag;
        bit                           echo_flag;
        logic [adsr_pkg::LEVEL_W-1:0] level;
        logic [adsr_pkg::LEVEL_W-1:0] echo_left;
        logic [adsr_pkg::LEVEL_W-1:0] attack_step;
        logic [adsr_pkg::LEVEL_W-1:0] decay_factor;
        logic [adsr_pkg::LEVEL_W-1:0] sustain_level;
        logic [adsr_pkg::LEVEL_W-1:0] release_factor;
        adsr_pkg::t_out_item          expected_q[$];
        int unsigned                  errors;

        function new();
            silence();
            level          = '0;
            echo_left      = '0;
            attack_step    = '0;
            decay_factor   = '0;
            sustain_level  = '0;
            release_factor = '0;
            errors         = 0;
        endfunction

        function bit sounding();
            return start_pending || stop_flag || echo_flag || phase != adsr_pkg::PH_NONE;
        endfunction

        function void silence();
            phase         = adsr_pkg::PH_NONE;
            start_pending = 1'b0;
            stop_flag     = 1'b0;
            echo_flag     = 1'b0;
        endfunction

        // threshold reached: echo tail, or the voice ends on an empty tail
        function void reach_echo();
            if (echo_left == '0) begin
                silence();
            end else begin
                echo_flag = 1'b1;
            end
        endfunction

        function void attack_frame();
            logic [adsr_pkg::LEVEL_W:0] sum;
            sum = {1'b0, level} + {1'b0, attack_step};
            // exactly full stays in attack for one more frame
            if (sum > {1'b0, adsr_pkg::LEVEL_MAX}) begin
                level = adsr_pkg::LEVEL_MAX;
                phase = adsr_pkg::PH_DECAY;
            end else begin
                level = sum[adsr_pkg::LEVEL_W-1:0];
            end
        endfunction

        function logic [adsr_pkg::LEVEL_W-1:0] scaled(
            input logic [adsr_pkg::LEVEL_W-1:0] v,
            input logic [adsr_pkg::LEVEL_W-1:0] f);
            logic [2*adsr_pkg::LEVEL_W-1:0] prod;
            prod = v * f;
            return prod[2*adsr_pkg::LEVEL_W-1:adsr_pkg::LEVEL_W];
        endfunction

        function void advance_frame();
            if (!sounding()) return;
            if (start_pending) begin
                // note on and note off both waiting cancel the voice
                if (stop_flag) begin
                    silence();
                end else begin
                    start_pending = 1'b0;
                    phase         = adsr_pkg::PH_ATTACK;
                    level         = '0;
                    attack_frame();
                end
                return;
            end
            if (echo_flag) begin
                echo_left = echo_left - 1'b1;
                if (echo_left == '0) silence();
                return;
            end
            if (stop_flag) begin
                level = scaled(level, release_factor);
                if (level <= echo_left) reach_echo();
                return;
            end
            if (phase == adsr_pkg::PH_ATTACK) begin
                attack_frame();
            end else if (phase == adsr_pkg::PH_DECAY) begin
                level = scaled(level, decay_factor);
                if (level <= sustain_level) begin
                    if (sustain_level == '0) begin
                        reach_echo();
                    end else begin
                        level = sustain_level;
                        phase = adsr_pkg::PH_SUSTAIN;
                    end
                end
            end
        endfunction

        function logic [adsr_pkg::STAGE_W-1:0] stage_now();
            if (!sounding())                    return adsr_pkg::STAGE_IDLE;
            if (echo_flag)                      return adsr_pkg::STAGE_ECHO;
            if (stop_flag)                      return adsr_pkg::STAGE_RELEASE;
            if (start_pending)                  return adsr_pkg::STAGE_ATTACK;
            if (phase == adsr_pkg::PH_ATTACK)   return adsr_pkg::STAGE_ATTACK;
            if (phase == adsr_pkg::PH_DECAY)    return adsr_pkg::STAGE_DECAY;
            if (phase == adsr_pkg::PH_SUSTAIN)  return adsr_pkg::STAGE_SUSTAIN;
            return adsr_pkg::STAGE_RELEASE;
        endfunction

        // accepted input transaction: update the voice, queue its result
        function void note_input(input adsr_pkg::t_in_item it);
            adsr_pkg::t_out_item res;
            case (it.action)
                adsr_pkg::ACT_TICK: begin
                    advance_frame();
                end
                adsr_pkg::ACT_NOTE_ON: begin
                    attack_step    = it.attack_step;
                    decay_factor   = it.decay_factor;
                    sustain_level  = it.sustain_level;
                    release_factor = it.release_factor;
                    echo_left      = it.echo_level;
                    phase          = adsr_pkg::PH_NONE;
                    stop_flag      = 1'b0;
                    echo_flag      = 1'b0;
                    start_pending  = 1'b1;
                end
                adsr_pkg::ACT_NOTE_OFF: begin
                    if (sounding()) stop_flag = 1'b1;
                end
                default: begin
                end
            endcase
            res.active         = sounding();
            res.envelope_level = level;
            res.stage          = stage_now();
            expected_q.push_back(res);
        endfunction

        // accepted output transaction: compare against the oldest expectation
        function void check_result(input adsr_pkg::t_out_item got);
            adsr_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result active=%0d level=%0d stage=%0d",
                         $time, got.active, got.envelope_level, got.stage);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.active !== want.active) begin
                $display("%0t: active mismatch, expected %0d, actual %0d",
                         $time, want.active, got.active);
                errors++;
            end
            if (got.envelope_level !== want.envelope_level) begin
                $display("%0t: level mismatch, expected %0d, actual %0d",
                         $time, want.envelope_level, got.envelope_level);
                errors++;
            end
            if (got.stage !== want.stage) begin
                $display("%0t: stage mismatch, expected %0d, actual %0d",
                         $time, want.stage, got.stage);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, dut
    // ------------------------------------------------------------------------
    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    adsr_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_stall;
    adsr_pkg::t_out_item o_data;

    envelope_scoreboard sb = new();

    int unsigned items_sent  = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          hold_armed  = 1'b0;
    int unsigned cycle_count = 0;

    adsr_echo_envelope u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // output side: stall pattern driven at the falling edge, with one long
    // hold-off so the single result register backs up into the input
    // ------------------------------------------------------------------------
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // every result transaction is checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    function automatic adsr_pkg::t_in_item rand_item(
        input logic [adsr_pkg::ACTION_W-1:0] act);
        adsr_pkg::t_in_item it;
        it.action         = act;
        it.attack_step    = adsr_pkg::LEVEL_W'($urandom);
        it.decay_factor   = adsr_pkg::LEVEL_W'($urandom);
        it.sustain_level  = adsr_pkg::LEVEL_W'($urandom);
        it.release_factor = adsr_pkg::LEVEL_W'($urandom);
        it.echo_level     = adsr_pkg::LEVEL_W'($urandom);
        return it;
    endfunction

    function automatic adsr_pkg::t_in_item note_on_item(
        input logic [adsr_pkg::LEVEL_W-1:0] atk,
        input logic [adsr_pkg::LEVEL_W-1:0] dcy,
        input logic [adsr_pkg::LEVEL_W-1:0] sus,
        input logic [adsr_pkg::LEVEL_W-1:0] rel,
        input logic [adsr_pkg::LEVEL_W-1:0] echo);
        adsr_pkg::t_in_item it;
        it.action         = adsr_pkg::ACT_NOTE_ON;
        it.attack_step    = atk;
        it.decay_factor   = dcy;
        it.sustain_level  = sus;
        it.release_factor = rel;
        it.echo_level     = echo;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance;
    // valid stays high between back-to-back transactions
    task automatic send_item(input adsr_pkg::t_in_item it);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_item(rand_item(adsr_pkg::ACT_TICK));
    endtask

    // sender pauses until every queued result has been taken
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic run_directed();
        // note off, tick and the unused code on an idle voice
        send_item(rand_item(adsr_pkg::ACT_NOTE_OFF));
        send_ticks(1);
        send_item(rand_item(ACT_UNUSED));
        // attack lands on exactly full, waits a frame, then decay to sustain
        send_item(note_on_item(8'd85, 8'h80, 8'h40, 8'h00, 8'd2));
        send_ticks(6);
        send_item(rand_item(ACT_UNUSED));
        // release drops straight to zero, two-frame echo tail, then idle
        send_item(rand_item(adsr_pkg::ACT_NOTE_OFF));
        send_ticks(3);
        // note on and note off before the tick cancel the voice
        send_item(note_on_item(8'hC7, 8'hC7, 8'hC7, 8'hC7, 8'hC7));
        send_item(rand_item(adsr_pkg::ACT_NOTE_OFF));
        send_ticks(1);
        // sustain of zero with no echo ends the voice, level stays shown
        send_item(note_on_item(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00));
        send_ticks(3);
        // zero attack never climbs, release at zero ends at once
        send_item(note_on_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_ticks(1);
        send_item(rand_item(adsr_pkg::ACT_NOTE_OFF));
        send_ticks(1);
        wait_drained();
    endtask

    // mostly complete notes with random content, some raw noise
    task automatic random_sequence();
        adsr_pkg::t_in_item it;
        if ($urandom_range(0, 9) < 8) begin
            it = rand_item(adsr_pkg::ACT_NOTE_ON);
            // short echo tails half of the time so notes finish
            if ($urandom_range(0, 1) == 0) begin
                it.echo_level = adsr_pkg::LEVEL_W'($urandom_range(0, 8));
            end
            send_item(it);
            send_ticks($urandom_range(1, 24));
            if ($urandom_range(0, 4) != 0) begin
                send_item(rand_item(adsr_pkg::ACT_NOTE_OFF));
                send_ticks($urandom_range(0, 30));
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                send_item(rand_item(adsr_pkg::ACTION_W'($urandom_range(0, 3))));
            end
        end
    endtask

    task automatic run_random(input int unsigned tx_pct, input int unsigned rx_pct,
                              input int unsigned n);
        int unsigned stop_at;
        stop_at     = items_sent + n;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (items_sent < stop_at) random_sequence();
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        run_random(11, 64, ITEMS_PER_RUN);
        run_random(64, 11, ITEMS_PER_RUN);
        // no idling from here on, but the output holds off once at the start
        hold_armed = 1'b1;
        run_random(0, 0, ITEMS_PER_RUN);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
src/adsr_pkg.sv
src/adsr_echo_envelope.sv
sim/testbench.sv
